// ----- rtl/automaton_string_match_counter_defines.svh -----
// Assertion macros for the string match counter checker.
// Each macro expects signals clk and rst_n in scope.
`ifndef AUTOMATON_STRING_MATCH_COUNTER_DEFINES_SVH
`define AUTOMATON_STRING_MATCH_COUNTER_DEFINES_SVH

// Same-cycle implication, disabled in reset
`define ASMC_ASSERT_NOW(name, cond, expr) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (expr)) \
        else $error("string match counter check failed");

// Next-cycle implication, disabled in reset
`define ASMC_ASSERT_NEXT(name, cond, expr) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (expr)) \
        else $error("string match counter check failed");

`endif

// ----- rtl/asmc_pkg.sv -----
// Shared types and constants of the string match counter.
// No dependencies.
package asmc_pkg;

    localparam int BYTE_W     = 8;
    localparam int PATTERN_W  = 64;
    localparam int LEN_W      = 4;
    localparam int Q_W        = 3;
    localparam int OUT_CNT_W  = 32;
    localparam int CFG_IDX_W  = 1;

    // Configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_PATTERN_BYTES  = 1'b0,
        REG_PATTERN_LENGTH = 1'b1
    } cfg_reg_t;

    // Outcome of one byte through the automaton
    typedef struct packed {
        logic           found;
        logic [Q_W-1:0] q;
    } step_t;

endpackage

// ----- rtl/asmc_next_state.sv -----
// Next matched-prefix length for one text byte, by parallel byte compares.
// Depends on asmc_pkg.
module asmc_next_state
    import asmc_pkg::*;
#(
    parameter int MAX_PATTERN = 8,
    parameter int HIST_DEPTH  = 7
)
(
    input  logic [PATTERN_W-1:0]               pattern,
    input  logic [LEN_W-1:0]                   pattern_len,
    input  logic [Q_W-1:0]                     q,
    input  logic                               start,
    input  logic [HIST_DEPTH-1:0][BYTE_W-1:0]  hist,
    input  logic [BYTE_W-1:0]                  text_byte,
    output step_t                              step
);

    logic [MAX_PATTERN-1:0] cand_ok;
    logic [LEN_W-1:0]       len_eff;
    logic [LEN_W-1:0]       top;
    logic [LEN_W-1:0]       q_start;
    logic [LEN_W-1:0]       next_k;

    // Candidate k: pattern byte k-1 equals the byte, earlier bytes equal history
    for (genvar k = 1; k <= MAX_PATTERN; k++) begin : g_cand
        logic [k-1:0] eq;
        assign eq[0] = (pattern[BYTE_W*(k-1) +: BYTE_W] == text_byte);
        for (genvar j = 0; j < k - 1; j++) begin : g_hist
            assign eq[j+1] = (pattern[BYTE_W*j +: BYTE_W] == hist[k-2-j]);
        end
        assign cand_ok[k-1] = &eq;
    end

    // Length clamp: zero acts as one, above maximum acts as maximum
    always_comb
    begin
        priority if (pattern_len == '0)
            len_eff = LEN_W'(1);
        else if (pattern_len > LEN_W'(MAX_PATTERN))
            len_eff = LEN_W'(MAX_PATTERN);
        else
            len_eff = pattern_len;
    end

    // Highest candidate allowed: min(q + 1, length), q cleared on start
    assign q_start = start ? '0 : LEN_W'(q);
    assign top     = ((q_start + LEN_W'(1)) > len_eff) ? len_eff : (q_start + LEN_W'(1));

    // Largest valid candidate not above top
    always_comb
    begin
        next_k = '0;
        for (int k = 1; k <= MAX_PATTERN; k++)
        begin
            if (cand_ok[k-1] && (LEN_W'(k) <= top))
                next_k = LEN_W'(k);
        end
    end

    // Full match counts and returns to zero
    assign step.found = (next_k == len_eff);
    assign step.q     = step.found ? '0 : next_k[Q_W-1:0];

endmodule

// ----- rtl/automaton_string_match_counter.sv -----
// Top level of the streaming string match counter.
// Depends on asmc_pkg and asmc_next_state.
//
//  channel   direction  handshake            payload
//  input     in         in_valid / in_stall   text_byte, start_of_text
//  output    out        out_valid / out_stall match_found, match_count, matched_length
//  config    in         cfg_write             cfg_index, cfg_data
//
// One byte is taken per cycle while in_stall is low; a result is registered when its byte leaves the input register.
// The next prefix length is found combinationally by comparing all pattern bytes
// against the byte and the recent-byte history in parallel.
// Reset clears the pattern, sets length to one, and clears state and count.
// A stalled output holds; the input register then stalls the input side.
module automaton_string_match_counter
    import asmc_pkg::*;
#(
    parameter int MAX_PATTERN = 8,
    parameter int COUNT_WIDTH = 32
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    // text input
    input  logic                  in_valid,
    output logic                  in_stall,
    input  logic [BYTE_W-1:0]     text_byte,
    input  logic                  start_of_text,
    // result output
    output logic                  out_valid,
    input  logic                  out_stall,
    output logic                  match_found,
    output logic [OUT_CNT_W-1:0]  match_count,
    output logic [Q_W-1:0]        matched_length,
    // configuration writes
    input  logic                  cfg_write,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [PATTERN_W-1:0]  cfg_data
);

    localparam int HIST_DEPTH = (MAX_PATTERN > 1) ? (MAX_PATTERN - 1) : 1;
    localparam logic [COUNT_WIDTH-1:0] COUNT_MAX = '1;

    logic [PATTERN_W-1:0]              pattern_reg;
    logic [LEN_W-1:0]                  length_reg;

    logic                              in_valid_reg;
    logic                              in_valid_next;
    logic [BYTE_W-1:0]                 byte_reg;
    logic                              start_reg;

    logic [Q_W-1:0]                    q_reg;
    logic [HIST_DEPTH-1:0][BYTE_W-1:0] hist_reg;
    logic [COUNT_WIDTH-1:0]            count_reg;
    logic [COUNT_WIDTH-1:0]            count_next;
    logic [COUNT_WIDTH-1:0]            count_base;

    logic                              out_valid_reg;
    logic                              out_valid_next;
    logic                              found_reg;
    logic [OUT_CNT_W-1:0]              out_count_reg;
    logic [Q_W-1:0]                    out_q_reg;

    logic                              out_free;
    logic                              advance;
    logic                              in_take;
    step_t                             step;

    // Handshake: the input register moves on whenever the result register frees up
    assign out_free = !out_valid_reg || !out_stall;
    assign advance  = in_valid_reg && out_free;
    assign in_stall = in_valid_reg && !out_free;
    assign in_take  = in_valid && !in_stall;

    assign in_valid_next  = in_take ? 1'b1 : (advance ? 1'b0 : in_valid_reg);
    assign out_valid_next = advance ? 1'b1 : (out_free ? 1'b0 : out_valid_reg);

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pattern_reg <= '0;
            length_reg  <= LEN_W'(1);
        end
        else if (cfg_write)
        begin
            unique case (cfg_reg_t'(cfg_index))
                REG_PATTERN_BYTES:  pattern_reg <= cfg_data;
                REG_PATTERN_LENGTH: length_reg  <= cfg_data[LEN_W-1:0];
                default:            pattern_reg <= pattern_reg;
            endcase
        end
    end

    // Input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else
            in_valid_reg <= in_valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            byte_reg  <= text_byte;
            start_reg <= start_of_text;
        end
    end

    // Automaton step
    asmc_next_state #(
        .MAX_PATTERN (MAX_PATTERN),
        .HIST_DEPTH  (HIST_DEPTH)
    ) u_next_state (
        .pattern     (pattern_reg),
        .pattern_len (length_reg),
        .q           (q_reg),
        .start       (start_reg),
        .hist        (hist_reg),
        .text_byte   (byte_reg),
        .step        (step)
    );

    // Saturating occurrence count, cleared on start
    assign count_base = start_reg ? '0 : count_reg;
    assign count_next = (step.found && (count_base != COUNT_MAX))
                        ? (count_base + COUNT_WIDTH'(1)) : count_base;

    // Matcher state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            q_reg     <= '0;
            hist_reg  <= '0;
            count_reg <= '0;
        end
        else if (advance)
        begin
            q_reg     <= step.q;
            count_reg <= count_next;
            for (int i = HIST_DEPTH - 1; i > 0; i--)
            begin
                hist_reg[i] <= hist_reg[i-1];
            end
            hist_reg[0] <= byte_reg;
        end
    end

    // Result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else
            out_valid_reg <= out_valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            found_reg     <= step.found;
            out_count_reg <= OUT_CNT_W'(count_next);
            out_q_reg     <= step.q;
        end
    end

    assign out_valid      = out_valid_reg;
    assign match_found    = found_reg;
    assign match_count    = out_count_reg;
    assign matched_length = out_q_reg;

endmodule

// ----- rtl/asmc_checker.sv -----
// Port-level checks for the string match counter, bound to the top level.
// Depends on asmc_pkg and automaton_string_match_counter_defines.svh.
`include "automaton_string_match_counter_defines.svh"

module asmc_checker
    import asmc_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    input  logic                  in_stall,
    input  logic                  out_valid,
    input  logic                  out_stall,
    input  logic                  match_found,
    input  logic [OUT_CNT_W-1:0]  match_count,
    input  logic [Q_W-1:0]        matched_length
);

    // A completed occurrence always leaves the prefix length at zero
    `ASMC_ASSERT_NOW(a_found_clears_q, out_valid && match_found, matched_length == '0)

    // A reported occurrence means the count is not zero
    `ASMC_ASSERT_NOW(a_found_counts, out_valid && match_found, match_count != '0)

    // The input side only stalls behind a held result
    `ASMC_ASSERT_NOW(a_stall_cause, in_stall, out_valid && out_stall)

    // A stalled result holds its count
    `ASMC_ASSERT_NEXT(a_hold_count, out_valid && out_stall, out_valid && $stable(match_count))

endmodule

bind automaton_string_match_counter asmc_checker u_asmc_checker (.*);
